// ----- rtl/core/fly_camera_orientation_update_top_macros.svh -----
// Assertion macros for the fly camera orientation update block.
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FCOU_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fcou check failed");
`define FCOU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fcou check failed");
`else
`define FCOU_ASSERT_IMPL(lbl, ante, cons)
`define FCOU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/core/fcou_pkg.sv -----
// Shared types, constants and tables of the fly camera orientation update block.
package fcou_pkg;

	localparam int TRIG_STEPS = 16;
	localparam int TRIG_IW = $clog2(TRIG_STEPS);

	typedef logic signed [32:0] wide_t;
	typedef logic signed [15:0] unit_t;

	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	localparam logic [1:0] OP_YAW   = 2'd0;
	localparam logic [1:0] OP_PITCH = 2'd1;
	localparam logic [1:0] OP_MOVE  = 2'd2;
	localparam logic [1:0] OP_MODE  = 2'd3;

	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_FIRST   = 2'd1;
	localparam logic [1:0] MODE_THIRD   = 2'd2;

	localparam logic [2:0] CFG_MOVE_SPEED = 3'd0;
	localparam logic [2:0] CFG_PITCH_MAX  = 3'd1;
	localparam logic [2:0] CFG_PITCH_MIN  = 3'd2;
	localparam logic [2:0] CFG_WORLD_UP_X = 3'd3;
	localparam logic [2:0] CFG_WORLD_UP_Y = 3'd4;
	localparam logic [2:0] CFG_WORLD_UP_Z = 3'd5;

	localparam logic signed [14:0] YAW_RESET   = -15'sd5760;
	localparam logic signed [13:0] PITCH_RESET = -14'sd1600;
	localparam logic signed [13:0] PITCH_LEVEL = 14'sd0;
	localparam logic signed [31:0] POS_THIRD_Y = 32'sd1310720;
	localparam logic signed [31:0] POS_THIRD_Z = 32'sd2621440;
	localparam logic signed [31:0] POS_DEF_Y   = 32'sd131072;
	localparam logic signed [31:0] POS_DEF_Z   = 32'sd1310720;

	function automatic logic [27:0] atan_deg(input logic [4:0] idx);
		logic [27:0] v;
		case (idx)
			5'd0: v = 28'd188743680;
			5'd1: v = 28'd111421900;
			5'd2: v = 28'd58872272;
			5'd3: v = 28'd29884485;
			5'd4: v = 28'd15000234;
			5'd5: v = 28'd7507429;
			5'd6: v = 28'd3754631;
			5'd7: v = 28'd1877430;
			5'd8: v = 28'd938729;
			5'd9: v = 28'd469366;
			5'd10: v = 28'd234683;
			5'd11: v = 28'd117342;
			5'd12: v = 28'd58671;
			5'd13: v = 28'd29335;
			5'd14: v = 28'd14668;
			5'd15: v = 28'd7334;
			5'd16: v = 28'd3667;
			5'd17: v = 28'd1833;
			5'd18: v = 28'd917;
			5'd19: v = 28'd458;
			5'd20: v = 28'd229;
			5'd21: v = 28'd115;
			5'd22: v = 28'd57;
			5'd23: v = 28'd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/fcou_cordic.sv -----
// Iterative CORDIC sine and cosine of a Q10.6 degree angle, Q2.30 results.
module fcou_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [15:0]  angle,
	output logic                done,
	output logic signed [31:0]  sin_out,
	output logic signed [31:0]  cos_out
);

	logic signed [32:0] x_q, y_q, xs, ys, xn, yn;
	logic signed [31:0] z_q, zn, at;
	logic [fcou_pkg::TRIG_IW-1:0] i_q;
	logic busy_q, flip_q, done_q;
	logic signed [15:0] a_red;
	logic a_flip;

	always_comb begin
		a_flip = 1'b0;
		a_red = angle;
		if (angle > 16'sd5760) begin
			a_red = angle - 16'sd11520;
			a_flip = 1'b1;
		end else if (angle < -16'sd5760) begin
			a_red = angle + 16'sd11520;
			a_flip = 1'b1;
		end
	end

	always_comb begin
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = $signed({4'b0, fcou_pkg::atan_deg(5'(i_q))});
		if (z_q >= 0) begin
			xn = x_q - ys;
			yn = y_q + xs;
			zn = z_q - at;
		end else begin
			xn = x_q + ys;
			yn = y_q - xs;
			zn = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			i_q <= '0;
			busy_q <= 1'b0;
			flip_q <= 1'b0;
			done_q <= 1'b0;
			sin_out <= '0;
			cos_out <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q <= fcou_pkg::CORDIC_GAIN;
				y_q <= '0;
				z_q <= $signed({a_red, 16'b0});
				i_q <= '0;
				flip_q <= a_flip;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				i_q <= i_q + 1'b1;
				if (i_q == fcou_pkg::TRIG_IW'(fcou_pkg::TRIG_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					sin_out <= flip_q ? 32'(-yn) : 32'(yn);
					cos_out <= flip_q ? 32'(-xn) : 32'(xn);
				end
			end
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/core/fcou_norm.sv -----
// Iterative vector normalizer: range shift, sum of squares, square root, division.
module fcou_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  fcou_pkg::wide_t vec_in [3],
	output logic            done,
	output fcou_pkg::unit_t vec_out [3]
);

	typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV} nstate_t;

	nstate_t state_q;
	logic [32:0] m_in [3];
	logic [32:0] mx_in;
	logic [32:0] mag_q [3];
	logic [32:0] mx_q;
	logic [2:0] neg_q;
	logic [59:0] sq_q;
	logic [61:0] sum_q;
	logic [62:0] rn_q, rr_q, rb_q, rt;
	logic [5:0] cnt_q;
	logic [1:0] cmp_q;
	logic [4:0] dcnt_q;
	logic [46:0] rem_q, dv_q;
	logic [15:0] quo_q, qn;
	logic [29:0] msel;
	logic ge, done_q;

	always_comb begin
		for (int k = 0; k < 3; k++)
			m_in[k] = vec_in[k][32] ? 33'(-vec_in[k]) : 33'(vec_in[k]);
		mx_in = m_in[0];
		if (m_in[1] > mx_in) mx_in = m_in[1];
		if (m_in[2] > mx_in) mx_in = m_in[2];
	end

	always_comb begin
		msel = (state_q == N_SQ) ? mag_q[cnt_q[1:0]][29:0] : mag_q[cmp_q][29:0];
		rt = rr_q + rb_q;
		ge = rem_q >= dv_q;
		qn = {quo_q[14:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= '0;
				vec_out[k] <= '0;
			end
			mx_q <= '0;
			neg_q <= '0;
			sq_q <= '0;
			sum_q <= '0;
			rn_q <= '0;
			rr_q <= '0;
			rb_q <= '0;
			cnt_q <= '0;
			cmp_q <= '0;
			dcnt_q <= '0;
			rem_q <= '0;
			dv_q <= '0;
			quo_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int k = 0; k < 3; k++) begin
							mag_q[k] <= m_in[k];
							neg_q[k] <= vec_in[k][32];
						end
						mx_q <= mx_in;
						if (mx_in == '0) begin
							for (int k = 0; k < 3; k++)
								vec_out[k] <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= N_SHIFT;
						end
					end
				end
				N_SHIFT: begin
					if (mx_q[32:30] != '0) begin
						for (int k = 0; k < 3; k++)
							mag_q[k] <= mag_q[k] >> 1;
						mx_q <= mx_q >> 1;
					end else if (!mx_q[29]) begin
						for (int k = 0; k < 3; k++)
							mag_q[k] <= mag_q[k] << 1;
						mx_q <= mx_q << 1;
					end else begin
						state_q <= N_SQ;
						cnt_q <= '0;
						sum_q <= '0;
					end
				end
				N_SQ: begin
					sq_q <= msel * msel;
					if (cnt_q != '0)
						sum_q <= sum_q + 62'(sq_q);
					if (cnt_q == 6'd3) begin
						rn_q <= 63'(sum_q) + 63'(sq_q);
						rr_q <= '0;
						rb_q <= 63'(1) << 62;
						cnt_q <= '0;
						state_q <= N_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				N_SQRT: begin
					if (rn_q >= rt) begin
						rn_q <= rn_q - rt;
						rr_q <= (rr_q >> 1) + rb_q;
					end else begin
						rr_q <= rr_q >> 1;
					end
					rb_q <= rb_q >> 2;
					if (cnt_q == 6'd31) begin
						state_q <= N_DIV;
						cmp_q <= '0;
						dcnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				N_DIV: begin
					if (dcnt_q == '0) begin
						rem_q <= 47'({msel, 14'b0}) + 47'(rr_q[31:1]);
						dv_q <= {rr_q[31:0], 15'b0};
						quo_q <= '0;
						dcnt_q <= 5'd1;
					end else begin
						if (ge)
							rem_q <= rem_q - dv_q;
						quo_q <= qn;
						dv_q <= dv_q >> 1;
						if (dcnt_q == 5'd16) begin
							vec_out[cmp_q] <= neg_q[cmp_q] ? -$signed(qn) : $signed(qn);
							dcnt_q <= '0;
							if (cmp_q == 2'd2) begin
								state_q <= N_IDLE;
								done_q <= 1'b1;
							end else begin
								cmp_q <= cmp_q + 1'b1;
							end
						end else begin
							dcnt_q <= dcnt_q + 1'b1;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/core/fly_camera_orientation_update_top.sv -----
// Top level of the fly camera orientation update block: sequencer, state and channels.
//
// Input channel (in_valid/in_ready) takes one command beat: rotate yaw, rotate
// pitch, move tick or mode preset. Output channel (out_valid/out_ready) returns
// one beat per command with position, front, camera up, yaw, pitch and mode as
// they stand after the command.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes speed,
// pitch limits and world up; cfg_ready is always high. World up takes effect at
// the next basis recompute.
// One command at a time. A rotation or preset runs a basis recompute: two
// CORDIC passes, the front products on the shared multiplier, two cross
// products and three normalizations, each with a range shift, 32 square
// root steps and three divisions. A move tick checks the six direction
// flags in turn; for each flagged direction it scales the direction and
// adds it to each of the three position axes. A preset with an unknown mode
// skips the recompute and goes straight to the output.
// After reset the block runs one basis recompute from the reset angles, with
// in_ready low, before it takes its first command.
// Results sit in an output register: the next command is accepted while a beat
// waits, and a finished command holds until the waiting beat is taken.
`include "fly_camera_orientation_update_top_macros.svh"
module fly_camera_orientation_update_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic signed [15:0] angle_delta,
	input  logic [15:0]        delta_time,
	input  logic [5:0]         move_flags,
	input  logic [1:0]         mode_select,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z,
	output logic signed [15:0] cam_up_x,
	output logic signed [15:0] cam_up_y,
	output logic signed [15:0] cam_up_z,
	output logic signed [14:0] yaw_out,
	output logic signed [13:0] pitch_out,
	output logic [1:0]         mode_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_TRIG_Y, S_WAIT_Y, S_TRIG_P, S_WAIT_P, S_FMUL, S_NORM_F, S_WAIT_F,
		S_CROSS_R, S_NORM_R, S_WAIT_R, S_CROSS_U, S_NORM_U, S_WAIT_U, S_MOVE, S_OUT
	} state_t;

	typedef enum logic [1:0] {MV_CHECK, MV_SCALE, MV_APPLY} mphase_t;

	state_t state_q;
	mphase_t mv_ph_q;
	logic boot_q;

	logic [15:0] speed_q;
	logic signed [13:0] pmax_q, pmin_q;
	fcou_pkg::unit_t wup_q [3];

	logic signed [14:0] yaw_q;
	logic signed [13:0] pitch_q;
	logic [1:0] mode_q;
	logic signed [31:0] pos_q [3];
	fcou_pkg::unit_t front_q [3], right_q [3], up_q [3];

	logic signed [31:0] sy_q, cy_q, sp_q, cp_q;
	fcou_pkg::wide_t f0_q, f2_q;
	fcou_pkg::wide_t cr_q [3];
	logic [2:0] cnt_q;
	logic [5:0] flags_q;
	logic [15:0] dt_q;
	logic [2:0] mv_f_q;
	logic [1:0] mv_k_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_q;

	logic out_valid_q;
	logic signed [31:0] o_pos_q [3];
	fcou_pkg::unit_t o_front_q [3], o_up_q [3];
	logic signed [14:0] o_yaw_q;
	logic signed [13:0] o_pitch_q;
	logic [1:0] o_mode_q;

	logic cor_start, cor_done, nrm_start, nrm_done;
	logic signed [15:0] cor_angle;
	logic signed [31:0] cor_sin, cor_cos;
	fcou_pkg::wide_t norm_in [3];
	fcou_pkg::unit_t norm_out [3];

	logic signed [17:0] ysum, ywrap, psum, pclamp;
	logic signed [14:0] yaw_new;
	logic signed [13:0] pitch_new;
	fcou_pkg::unit_t cu [3], cw [3];
	fcou_pkg::unit_t dsel;
	logic dneg;
	logic signed [16:0] dsign;
	logic signed [65:0] rsum;
	logic signed [33:0] pnext;
	logic signed [31:0] psat;
	logic accept, slot_free;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;

	// yaw wrap and pitch clamp
	always_comb begin
		ysum = 18'(yaw_q) + 18'(angle_delta) + 18'sd11520;
		if (ysum < -18'sd23040)
			ywrap = ysum + 18'sd46080;
		else if (ysum < 18'sd0)
			ywrap = ysum + 18'sd23040;
		else if (ysum >= 18'sd46080)
			ywrap = ysum - 18'sd46080;
		else if (ysum >= 18'sd23040)
			ywrap = ysum - 18'sd23040;
		else
			ywrap = ysum;
		yaw_new = 15'(ywrap - 18'sd11520);

		psum = 18'(pitch_q) + 18'(angle_delta);
		if (psum > 18'(pmax_q))
			pclamp = 18'(pmax_q);
		else if (psum < 18'(pmin_q))
			pclamp = 18'(pmin_q);
		else
			pclamp = psum;
		if (pclamp > 18'sd5760)
			pclamp = 18'sd5760;
		if (pclamp < -18'sd5760)
			pclamp = -18'sd5760;
		pitch_new = 14'(pclamp);
	end

	// move direction select
	always_comb begin
		case (mv_f_q)
			3'd0, 3'd1: dsel = front_q[mv_k_q];
			3'd2, 3'd3: dsel = right_q[mv_k_q];
			default: dsel = up_q[mv_k_q];
		endcase
		dneg = (mv_f_q == 3'd1) || (mv_f_q == 3'd2) || (mv_f_q == 3'd5);
		dsign = dneg ? -17'(dsel) : 17'(dsel);
		rsum = mul_q + 66'sd2097152;
		pnext = 34'(pos_q[mv_k_q]) + 34'(rsum[65:22]);
		if (pnext > 34'sd2147483647)
			psat = 32'sh7FFFFFFF;
		else if (pnext < -34'sd2147483648)
			psat = 32'sh80000000;
		else
			psat = 32'(pnext);
	end

	// cross operands
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cu[k] = (state_q == S_CROSS_R) ? front_q[k] : right_q[k];
			cw[k] = (state_q == S_CROSS_R) ? wup_q[k] : front_q[k];
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_FMUL: begin
				mul_a = (cnt_q == 3'd0) ? 33'(cy_q) : 33'(sy_q);
				mul_b = 33'(cp_q);
			end
			S_CROSS_R, S_CROSS_U: begin
				case (cnt_q)
					3'd0: begin mul_a = 33'(cu[1]); mul_b = 33'(cw[2]); end
					3'd1: begin mul_a = 33'(cu[2]); mul_b = 33'(cw[1]); end
					3'd2: begin mul_a = 33'(cu[2]); mul_b = 33'(cw[0]); end
					3'd3: begin mul_a = 33'(cu[0]); mul_b = 33'(cw[2]); end
					3'd4: begin mul_a = 33'(cu[0]); mul_b = 33'(cw[1]); end
					3'd5: begin mul_a = 33'(cu[1]); mul_b = 33'(cw[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			S_MOVE: begin
				if (mv_ph_q == MV_CHECK) begin
					mul_a = 33'(dsign);
					mul_b = $signed({17'b0, speed_q});
				end else begin
					mul_a = $signed(mul_q[32:0]);
					mul_b = $signed({17'b0, dt_q});
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		cor_start = (state_q == S_TRIG_Y) || (state_q == S_TRIG_P);
		cor_angle = (state_q == S_TRIG_Y) ? 16'(yaw_q) : 16'(pitch_q);
		nrm_start = (state_q == S_NORM_F) || (state_q == S_NORM_R) || (state_q == S_NORM_U);
		if (state_q == S_NORM_F) begin
			norm_in[0] = f0_q;
			norm_in[1] = 33'(sp_q);
			norm_in[2] = f2_q;
		end else begin
			for (int k = 0; k < 3; k++)
				norm_in[k] = cr_q[k];
		end
	end

	fcou_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_angle),
		.done    (cor_done),
		.sin_out (cor_sin),
		.cos_out (cor_cos)
	);

	fcou_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (nrm_start),
		.vec_in  (norm_in),
		.done    (nrm_done),
		.vec_out (norm_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TRIG_Y;
			mv_ph_q <= MV_CHECK;
			boot_q <= 1'b1;
			speed_q <= 16'd640;
			pmax_q <= 14'sd5696;
			pmin_q <= -14'sd5696;
			wup_q[0] <= 16'sd0;
			wup_q[1] <= 16'sd16384;
			wup_q[2] <= 16'sd0;
			yaw_q <= fcou_pkg::YAW_RESET;
			pitch_q <= fcou_pkg::PITCH_RESET;
			mode_q <= fcou_pkg::MODE_THIRD;
			pos_q[0] <= '0;
			pos_q[1] <= fcou_pkg::POS_THIRD_Y;
			pos_q[2] <= fcou_pkg::POS_THIRD_Z;
			for (int k = 0; k < 3; k++) begin
				front_q[k] <= '0;
				right_q[k] <= '0;
				up_q[k] <= '0;
				cr_q[k] <= '0;
				o_pos_q[k] <= '0;
				o_front_q[k] <= '0;
				o_up_q[k] <= '0;
			end
			sy_q <= '0;
			cy_q <= '0;
			sp_q <= '0;
			cp_q <= '0;
			f0_q <= '0;
			f2_q <= '0;
			cnt_q <= '0;
			flags_q <= '0;
			dt_q <= '0;
			mv_f_q <= '0;
			mv_k_q <= '0;
			mul_q <= '0;
			out_valid_q <= 1'b0;
			o_yaw_q <= '0;
			o_pitch_q <= '0;
			o_mode_q <= '0;
		end else begin
			mul_q <= mul_a * mul_b;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fcou_pkg::CFG_MOVE_SPEED: speed_q <= cfg_data;
					fcou_pkg::CFG_PITCH_MAX:  pmax_q <= $signed(cfg_data[13:0]);
					fcou_pkg::CFG_PITCH_MIN:  pmin_q <= $signed(cfg_data[13:0]);
					fcou_pkg::CFG_WORLD_UP_X: wup_q[0] <= $signed(cfg_data);
					fcou_pkg::CFG_WORLD_UP_Y: wup_q[1] <= $signed(cfg_data);
					fcou_pkg::CFG_WORLD_UP_Z: wup_q[2] <= $signed(cfg_data);
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							fcou_pkg::OP_YAW: begin
								yaw_q <= yaw_new;
								state_q <= S_TRIG_Y;
							end
							fcou_pkg::OP_PITCH: begin
								pitch_q <= pitch_new;
								state_q <= S_TRIG_Y;
							end
							fcou_pkg::OP_MOVE: begin
								flags_q <= move_flags;
								dt_q <= delta_time;
								mv_f_q <= '0;
								mv_k_q <= '0;
								mv_ph_q <= MV_CHECK;
								state_q <= S_MOVE;
							end
							default: begin
								case (mode_select)
									fcou_pkg::MODE_DEFAULT: begin
										pitch_q <= fcou_pkg::PITCH_LEVEL;
										yaw_q <= fcou_pkg::YAW_RESET;
										pos_q[0] <= '0;
										pos_q[1] <= fcou_pkg::POS_DEF_Y;
										pos_q[2] <= fcou_pkg::POS_DEF_Z;
										mode_q <= mode_select;
										state_q <= S_TRIG_Y;
									end
									fcou_pkg::MODE_FIRST: begin
										pitch_q <= fcou_pkg::PITCH_LEVEL;
										yaw_q <= fcou_pkg::YAW_RESET;
										mode_q <= mode_select;
										state_q <= S_TRIG_Y;
									end
									fcou_pkg::MODE_THIRD: begin
										pitch_q <= fcou_pkg::PITCH_RESET;
										pos_q[0] <= '0;
										pos_q[1] <= fcou_pkg::POS_THIRD_Y;
										pos_q[2] <= fcou_pkg::POS_THIRD_Z;
										mode_q <= mode_select;
										state_q <= S_TRIG_Y;
									end
									default: state_q <= S_OUT;
								endcase
							end
						endcase
					end
				end
				S_TRIG_Y: state_q <= S_WAIT_Y;
				S_WAIT_Y: begin
					if (cor_done) begin
						sy_q <= cor_sin;
						cy_q <= cor_cos;
						state_q <= S_TRIG_P;
					end
				end
				S_TRIG_P: state_q <= S_WAIT_P;
				S_WAIT_P: begin
					if (cor_done) begin
						sp_q <= cor_sin;
						cp_q <= cor_cos;
						cnt_q <= '0;
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd1)
						f0_q <= $signed(mul_q[62:30]);
					if (cnt_q == 3'd2) begin
						f2_q <= $signed(mul_q[62:30]);
						state_q <= S_NORM_F;
					end
				end
				S_NORM_F: state_q <= S_WAIT_F;
				S_WAIT_F: begin
					if (nrm_done) begin
						for (int k = 0; k < 3; k++)
							front_q[k] <= norm_out[k];
						cnt_q <= '0;
						state_q <= S_CROSS_R;
					end
				end
				S_CROSS_R, S_CROSS_U: begin
					cnt_q <= cnt_q + 1'b1;
					case (cnt_q)
						3'd1: cr_q[0] <= $signed(mul_q[32:0]);
						3'd2: cr_q[0] <= cr_q[0] - $signed(mul_q[32:0]);
						3'd3: cr_q[1] <= $signed(mul_q[32:0]);
						3'd4: cr_q[1] <= cr_q[1] - $signed(mul_q[32:0]);
						3'd5: cr_q[2] <= $signed(mul_q[32:0]);
						3'd6: cr_q[2] <= cr_q[2] - $signed(mul_q[32:0]);
						default: ;
					endcase
					if (cnt_q == 3'd6)
						state_q <= (state_q == S_CROSS_R) ? S_NORM_R : S_NORM_U;
				end
				S_NORM_R: state_q <= S_WAIT_R;
				S_WAIT_R: begin
					if (nrm_done) begin
						for (int k = 0; k < 3; k++)
							right_q[k] <= norm_out[k];
						cnt_q <= '0;
						state_q <= S_CROSS_U;
					end
				end
				S_NORM_U: state_q <= S_WAIT_U;
				S_WAIT_U: begin
					if (nrm_done) begin
						for (int k = 0; k < 3; k++)
							up_q[k] <= norm_out[k];
						boot_q <= 1'b0;
						state_q <= boot_q ? S_IDLE : S_OUT;
					end
				end
				S_MOVE: begin
					case (mv_ph_q)
						MV_CHECK: begin
							if (flags_q[mv_f_q]) begin
								mv_ph_q <= MV_SCALE;
							end else begin
								mv_k_q <= '0;
								if (mv_f_q == 3'd5)
									state_q <= S_OUT;
								else
									mv_f_q <= mv_f_q + 1'b1;
							end
						end
						MV_SCALE: mv_ph_q <= MV_APPLY;
						MV_APPLY: begin
							pos_q[mv_k_q] <= psat;
							mv_ph_q <= MV_CHECK;
							if (mv_k_q == 2'd2) begin
								mv_k_q <= '0;
								if (mv_f_q == 3'd5)
									state_q <= S_OUT;
								else
									mv_f_q <= mv_f_q + 1'b1;
							end else begin
								mv_k_q <= mv_k_q + 1'b1;
							end
						end
						default: mv_ph_q <= MV_CHECK;
					endcase
				end
				S_OUT: begin
					if (slot_free) begin
						for (int k = 0; k < 3; k++) begin
							o_pos_q[k] <= pos_q[k];
							o_front_q[k] <= front_q[k];
							o_up_q[k] <= up_q[k];
						end
						o_yaw_q <= yaw_q;
						o_pitch_q <= pitch_q;
						o_mode_q <= mode_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = o_pos_q[0];
	assign pos_y = o_pos_q[1];
	assign pos_z = o_pos_q[2];
	assign front_x = o_front_q[0];
	assign front_y = o_front_q[1];
	assign front_z = o_front_q[2];
	assign cam_up_x = o_up_q[0];
	assign cam_up_y = o_up_q[1];
	assign cam_up_z = o_up_q[2];
	assign yaw_out = o_yaw_q;
	assign pitch_out = o_pitch_q;
	assign mode_out = o_mode_q;

	`FCOU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`FCOU_ASSERT_IMPL(a_idle_after_boot, state_q == S_IDLE, !boot_q)
	`FCOU_ASSERT_IMPL(a_pitch_range, 1'b1, pitch_q <= 14'sd5760 && pitch_q >= -14'sd5760)
	`FCOU_ASSERT_IMPL(a_yaw_range, 1'b1, yaw_q <= 15'sd11519 && yaw_q >= -15'sd11520)

endmodule
